/* src/cwpa_pkg.sv */
// Package: shared constants and types for the way partition adjuster.
package cwpa_pkg;

   localparam int TASKS_DEF   = 8;
   localparam int CLASSES_DEF = 16;
   localparam int WAYS_DEF    = 20;

   localparam int HIT_W   = 48;
   localparam int OCC_W   = 20;
   localparam int IPC_W   = 16;
   localparam int SUM_W   = 20;
   localparam int IV_W    = 32;
   localparam int CPU_W   = 3;
   localparam int CLS_W   = 4;
   localparam int ACT_W   = 3;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_APPLY_EVERY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAYS_STEP   = 1'd1;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADDED     = 3'd0,
      ACT_REMOVED   = 3'd1,
      ACT_UNCHANGED = 3'd2,
      ACT_SKIPPED   = 3'd3,
      ACT_RESTORED  = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_PERIOD,
      ST_DIVIDE,
      ST_DECIDE,
      ST_SORT,
      ST_APPLY,
      ST_UNDO,
      ST_EMIT
   } state_type;

   // Control into the sort cell chain.
   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctl_type;

endpackage

/* src/cwpa_if.sv */
// Interfaces: valid/ready channels for task words and result words.
interface cwpa_req_if;
   import cwpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [CPU_W-1:0]    task_cpu;
   logic [CLS_W-1:0]    task_class;
   logic [HIT_W-1:0]    hit_count;
   logic [OCC_W-1:0]    occupancy_kb;
   logic [IPC_W-1:0]    task_ipc;
   logic [IV_W-1:0]     interval_number;
   logic                last_task;
   modport source (output valid, task_cpu, task_class, hit_count, occupancy_kb,
                   task_ipc, interval_number, last_task, input ready);
   modport sink   (input valid, task_cpu, task_class, hit_count, occupancy_kb,
                   task_ipc, interval_number, last_task, output ready);
endinterface

interface cwpa_rsp_if;
   import cwpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [CLS_W-1:0]    class_index;
   logic [WAYS_DEF-1:0] way_mask;
   logic [ACT_W-1:0]    action;
   logic                last_result;
   modport source (output valid, class_index, way_mask, action, last_result, input ready);
   modport sink   (input valid, class_index, way_mask, action, last_result, output ready);
endinterface

/* src/cwpa_div.sv */
// Restoring divider: hit count over occupancy or interval number over period, one quotient bit per cycle.
module cwpa_div
   import cwpa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [HIT_W-1:0] dividend,
   input  logic [OCC_W-1:0] divisor,
   output logic             done,
   output logic [HIT_W-1:0] quotient
);
   localparam int CNT_W = $clog2(HIT_W + 1);

   logic [HIT_W-1:0] quo_ff, quo_in;
   logic [OCC_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [OCC_W:0]   trial;
   logic [OCC_W:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[OCC_W-1:0], quo_ff[HIT_W-1]};
      diff    = trial - {1'b0, divisor};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(HIT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff;
            quo_in = {quo_ff[HIT_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[HIT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = busy_ff && cnt_ff == CNT_W'(1);
   // zero occupancy gives ratio 0
   assign quotient = (divisor == '0) ? '0 : quo_in;
endmodule

/* src/cwpa_cell.sv */
// Sort cell: holds one slot; insertion chain keeps entries descending by ratio.
module cwpa_cell
   import cwpa_pkg::*;
#(
   parameter int IDX_W = 3
)
(
   input  logic             clock,
   input  chain_ctl_type    ctl,
   input  logic [HIT_W-1:0] new_ratio,
   input  logic [IDX_W-1:0] new_idx,
   input  logic [HIT_W-1:0] up_ratio,
   input  logic [IDX_W-1:0] up_idx,
   input  logic             up_valid,
   input  logic             up_takes,
   input  logic             clear,
   output logic [HIT_W-1:0] ratio,
   output logic [IDX_W-1:0] idx,
   output logic             valid,
   output logic             takes
);
   logic [HIT_W-1:0] ratio_ff, ratio_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;

   // strict compare keeps earlier arrivals ahead on ties
   assign takes = up_takes || !valid_ff || (ratio_ff < new_ratio);

   always_comb begin
      ratio_in = ratio_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (ctl.load && takes) begin
         if (up_takes) begin
            ratio_in = up_ratio;
            idx_in   = up_idx;
            valid_in = up_valid;
         end else begin
            ratio_in = new_ratio;
            idx_in   = new_idx;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
      ratio_ff <= ratio_in;
      idx_ff   <= idx_in;
   end

   assign ratio = ratio_ff;
   assign idx   = idx_ff;
   assign valid = valid_ff;
endmodule

/* src/cache_way_partition_adjuster_top.sv */
// Top level: collects task words, adjusts class way masks, reports results.
//
// Usage: task words arrive on req, eight per interval, the eighth marked by
// last_task. Each accepted word makes two passes through one shared restoring
// divider: interval_number modulo apply_every decides whether the interval
// acts, then hit_count over occupancy_kb gives the ratio. req_ready stays low
// meanwhile, so no new task word is taken until both passes are through. On
// the last word of an acting interval the eight stored ratios are fed in slot
// order into a row of eight sort cells, the undo test is made, and the masks
// are updated or restored one position per cycle. The eight result words
// leave on rsp, one per cycle while rsp_ready is high. A stalled receiver
// holds the current result word; no task word is taken until all eight are
// delivered. Non-acting intervals give no result words.
// Synchronous reset sets all class masks to all ways, period and step to 1,
// and clears the skip flags, the change flag, the running and previous IPC
// sums and the counter.
module cache_way_partition_adjuster_top
   import cwpa_pkg::*;
#(
   parameter int NUM_TASKS   = TASKS_DEF,
   parameter int NUM_CLASSES = CLASSES_DEF,
   parameter int WAY_COUNT   = WAYS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   cwpa_req_if.sink             req,
   cwpa_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   localparam int IDX_W = $clog2(NUM_TASKS);
   localparam int CI_W  = $clog2(NUM_CLASSES);
   localparam logic [WAY_COUNT-1:0] WAY_TOP = {2'b11, {(WAY_COUNT-2){1'b0}}};

   state_type state_ff, state_in;

   logic [CSR_W-1:0] apply_ff;
   logic [4:0]       step_ff;

   logic [WAY_COUNT-1:0] mask_ff [NUM_CLASSES];
   logic [CPU_W-1:0]    tcpu_ff [NUM_TASKS];
   logic [CLS_W-1:0]    tcls_ff [NUM_TASKS];
   logic [HIT_W-1:0]    tratio_ff [NUM_TASKS];
   logic [CPU_W-1:0]    scpu_ff [NUM_TASKS];
   logic [CLS_W-1:0]    scls_ff [NUM_TASKS];
   logic [WAY_COUNT-1:0] smask_ff [NUM_TASKS];
   logic [7:0]          skip_ff;
   logic                changed_ff;
   logic [SUM_W-1:0]    prev_ff, sum_ff, total_ff;
   logic [IDX_W-1:0]    cnt_ff;
   logic [IDX_W:0]      pos_ff;
   logic [IDX_W-1:0]    k_idx;
   logic [CLS_W-1:0]    rcls_ff [NUM_TASKS];
   logic [ACT_W-1:0]    act_ff [NUM_TASKS];
   logic [IDX_W-1:0]    order_ff [NUM_TASKS];

   // held input word
   logic [CPU_W-1:0] h_cpu_ff;
   logic [CLS_W-1:0] h_cls_ff;
   logic [HIT_W-1:0] h_hit_ff;
   logic [OCC_W-1:0] h_occ_ff;
   logic [IV_W-1:0]  h_iv_ff;
   logic             h_last_ff;
   logic             acting_ff;

   // divider sharing
   logic             div_start, div_done;
   logic [HIT_W-1:0] div_a, div_q;
   logic [OCC_W-1:0] div_b;
   logic [CSR_W-1:0] period;
   logic             div_mode_ff; // 1: period check

   assign period = (apply_ff == '0) ? CSR_W'(1) : apply_ff;
   assign div_a  = div_mode_ff ? HIT_W'(h_iv_ff) : h_hit_ff;
   assign div_b  = div_mode_ff ? OCC_W'(period) : h_occ_ff;

   cwpa_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   // product for the period check: q*period, compared with iv
   logic [IV_W+CSR_W-1:0] prod;
   assign prod = div_q[IV_W-1:0] * period;

   // sort chain, loaded from the slots in slot order so ties keep slot order
   chain_ctl_type      ctl;
   logic [HIT_W-1:0]   c_ratio [NUM_TASKS];
   logic [IDX_W-1:0]   c_idx   [NUM_TASKS];
   logic               c_valid [NUM_TASKS];
   logic               c_takes [NUM_TASKS];
   logic               chain_clr;
   logic [HIT_W-1:0]   load_ratio;

   assign load_ratio = tratio_ff[k_idx];

   genvar g;
   generate
      for (g = 0; g < NUM_TASKS; g++) begin : g_cell
         if (g == 0) begin : g_head
            cwpa_cell #(.IDX_W(IDX_W)) u_cell (
               .clock(clock), .ctl(ctl), .new_ratio(load_ratio), .new_idx(k_idx),
               .up_ratio('0), .up_idx('0), .up_valid(1'b0), .up_takes(1'b0),
               .clear(chain_clr), .ratio(c_ratio[g]), .idx(c_idx[g]),
               .valid(c_valid[g]), .takes(c_takes[g])
            );
         end else begin : g_body
            cwpa_cell #(.IDX_W(IDX_W)) u_cell (
               .clock(clock), .ctl(ctl), .new_ratio(load_ratio), .new_idx(k_idx),
               .up_ratio(c_ratio[g-1]), .up_idx(c_idx[g-1]),
               .up_valid(c_valid[g-1]), .up_takes(c_takes[g-1]),
               .clear(chain_clr), .ratio(c_ratio[g]), .idx(c_idx[g]),
               .valid(c_valid[g]), .takes(c_takes[g])
            );
         end
      end
   endgenerate

   // apply order of sorted positions: 0,1,2,7,6,5,3,4
   function automatic logic [IDX_W-1:0] seq_pos(input logic [IDX_W-1:0] k);
      logic [IDX_W-1:0] r;
      unique case (k)
         3'd0: r = 3'd0;
         3'd1: r = 3'd1;
         3'd2: r = 3'd2;
         3'd3: r = 3'd7;
         3'd4: r = 3'd6;
         3'd5: r = 3'd5;
         3'd6: r = 3'd3;
         default: r = 3'd4;
      endcase
      return r;
   endfunction

   logic [IDX_W-1:0] a_pos, a_slot;
   logic [CPU_W-1:0] a_cpu;
   logic [CI_W-1:0]  a_q;
   logic [WAY_COUNT-1:0] a_m;
   logic [CLS_W-1:0] u_cls;
   logic             undo_cond;
   logic [SUM_W+10:0] lhs, rhs;

   assign k_idx  = pos_ff[IDX_W-1:0];
   assign a_pos  = seq_pos(k_idx);
   assign a_slot = order_ff[a_pos];
   assign a_cpu  = tcpu_ff[a_slot];
   assign a_q    = CI_W'(tcls_ff[a_slot]);
   assign a_m    = mask_ff[a_q];
   assign lhs    = (SUM_W+11)'(total_ff) * 11'd1000;
   assign rhs    = (SUM_W+11)'(prev_ff) * 11'd995;
   assign undo_cond = (lhs < rhs) && changed_ff;

   // undo class lookup: first slot with the saved cpu
   always_comb begin
      u_cls = scls_ff[k_idx];
      for (int j = NUM_TASKS - 1; j >= 0; j--) begin
         if (tcpu_ff[j] == scpu_ff[k_idx]) u_cls = tcls_ff[j];
      end
   end

   logic req_fire, rsp_fire;
   assign req.ready = (state_ff == ST_COLLECT);
   assign req_fire  = req.valid && req.ready;
   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign rsp.class_index = rcls_ff[k_idx];
   assign rsp.way_mask    = mask_ff[CI_W'(rcls_ff[k_idx])];
   assign rsp.action      = act_ff[k_idx];
   assign rsp.last_result = (k_idx == IDX_W'(NUM_TASKS - 1));

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      ctl       = '{load: 1'b0, shift: 1'b0};
      chain_clr = 1'b0;
      unique case (state_ff)
         ST_COLLECT: if (req_fire) begin
            state_in  = ST_PERIOD;
         end
         ST_PERIOD: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: if (div_done) begin
            if (div_mode_ff) begin
               // second pass starts once the mode has switched to the ratio
               state_in = ST_PERIOD;
            end else if (h_last_ff && acting_ff) begin
               state_in  = ST_SORT;
               chain_clr = 1'b1;
            end else begin
               state_in = ST_COLLECT;
            end
         end
         ST_SORT: begin
            ctl.load = 1'b1;
            if (k_idx == IDX_W'(NUM_TASKS - 1)) state_in = ST_DECIDE;
         end
         ST_DECIDE: state_in = undo_cond ? ST_UNDO : ST_APPLY;
         ST_APPLY: if (k_idx == IDX_W'(NUM_TASKS - 1)) state_in = ST_EMIT;
         ST_UNDO:  if (k_idx == IDX_W'(NUM_TASKS - 1)) state_in = ST_EMIT;
         ST_EMIT: if (rsp_fire && k_idx == IDX_W'(NUM_TASKS - 1)) begin
            state_in  = ST_COLLECT;
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_COLLECT;
         apply_ff    <= CSR_W'(1);
         step_ff     <= 5'd1;
         skip_ff     <= '0;
         changed_ff  <= 1'b0;
         prev_ff     <= '0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         pos_ff      <= '0;
         div_mode_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) mask_ff[i] <= '1;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_APPLY_EVERY: apply_ff <= csr_wdata;
               REG_WAYS_STEP:   step_ff  <= csr_wdata[4:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_COLLECT: if (req_fire) begin
               h_cpu_ff    <= req.task_cpu;
               h_cls_ff    <= req.task_class;
               h_hit_ff    <= req.hit_count;
               h_occ_ff    <= req.occupancy_kb;
               h_iv_ff     <= req.interval_number;
               h_last_ff   <= req.last_task;
               div_mode_ff <= 1'b1;
               if (SUM_W'(sum_ff + SUM_W'(req.task_ipc)) < sum_ff)
                  sum_ff <= '1;
               else
                  sum_ff <= sum_ff + SUM_W'(req.task_ipc);
            end
            ST_DIVIDE: if (div_done) begin
               if (div_mode_ff) begin
                  acting_ff   <= (prod[IV_W-1:0] == h_iv_ff);
                  div_mode_ff <= 1'b0;
               end else begin
                  tratio_ff[cnt_ff] <= div_q;
                  tcpu_ff[cnt_ff]   <= h_cpu_ff;
                  tcls_ff[cnt_ff]   <= h_cls_ff;
                  if (acting_ff && h_occ_ff == '0) skip_ff[h_cpu_ff] <= 1'b1;
                  if (h_last_ff) begin
                     cnt_ff   <= '0;
                     total_ff <= sum_ff;
                     sum_ff   <= '0;
                     pos_ff   <= '0;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            ST_SORT: begin
               if (k_idx == IDX_W'(NUM_TASKS - 1)) pos_ff <= '0;
               else pos_ff <= pos_ff + 1'b1;
            end
            ST_DECIDE: begin
               for (int i = 0; i < NUM_TASKS; i++) order_ff[i] <= c_idx[i];
               if (!undo_cond) begin
                  for (int i = 0; i < NUM_TASKS; i++) begin
                     scpu_ff[i]  <= tcpu_ff[i];
                     scls_ff[i]  <= tcls_ff[i];
                     smask_ff[i] <= mask_ff[CI_W'(tcls_ff[i])];
                     rcls_ff[i]  <= CLS_W'(CI_W'(tcls_ff[i]));
                  end
               end
            end
            ST_APPLY: begin
               if (a_pos == 3'd3 || a_pos == 3'd4) begin
                  skip_ff[a_cpu]  <= 1'b0;
                  act_ff[a_slot]  <= ACT_UNCHANGED;
               end else if (skip_ff[a_cpu]) begin
                  skip_ff[a_cpu]  <= 1'b0;
                  act_ff[a_slot]  <= ACT_SKIPPED;
               end else if (a_pos < 3'd3) begin
                  mask_ff[a_q]   <= a_m | (a_m >> step_ff);
                  act_ff[a_slot] <= ACT_ADDED;
               end else begin
                  mask_ff[a_q]   <= ((a_m << step_ff) & a_m) | WAY_TOP;
                  act_ff[a_slot] <= ACT_REMOVED;
               end
               if (k_idx == IDX_W'(NUM_TASKS - 1)) begin
                  pos_ff     <= '0;
                  changed_ff <= 1'b1;
                  prev_ff    <= total_ff;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            ST_UNDO: begin
               mask_ff[CI_W'(u_cls)] <= smask_ff[k_idx];
               rcls_ff[k_idx] <= CLS_W'(CI_W'(u_cls));
               act_ff[k_idx]  <= ACT_RESTORED;
               if (k_idx == IDX_W'(NUM_TASKS - 1)) begin
                  pos_ff     <= '0;
                  changed_ff <= 1'b0;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            ST_EMIT: if (rsp_fire) pos_ff <= pos_ff + 1'b1;
            default: ;
         endcase
      end
   end

   unused_shift_chk: assert property (@(posedge clock) !ctl.shift)
      else $error("shift unused");
   a_no_req_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("req taken while emitting");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_result |=> state_ff == ST_COLLECT)
      else $error("emit did not end");
endmodule
